// ----- sv/gcdb_pkg.sv -----
// Package for the great-circle distance and bearing pipeline.
// Holds Q30 constants, the CORDIC arctangent table and shared types.
// No dependencies.
`default_nettype none
package gcdb_pkg;

    localparam int QW = 34;
    localparam logic signed [QW-1:0] Q_ONE = QW'(64'sd1 << 30);
    localparam logic signed [QW-1:0] CORDIC_K0 = QW'(64'sd652032874);
    localparam logic [31:0] HALF_TURN = 32'h8000_0000;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [31:0] DIST_SCALE = 32'd1311768642;
    localparam int DIST_W = 15;
    localparam int BEAR_W = 9;

    localparam logic [1:0] REG_HOME_LON = 2'd0;
    localparam logic [1:0] REG_HOME_LAT = 2'd1;
    localparam logic [1:0] REG_HOME_VALID = 2'd2;

    typedef logic signed [QW-1:0] q30_t;

    function automatic logic signed [32:0] atan_turn(input int i);
        logic signed [32:0] t;
        t = '0;
        case (i)
            0: t = 33'sd536870912;
            1: t = 33'sd316933406;
            2: t = 33'sd167458907;
            3: t = 33'sd85004756;
            4: t = 33'sd42667331;
            5: t = 33'sd21354465;
            6: t = 33'sd10679838;
            7: t = 33'sd5340245;
            8: t = 33'sd2670163;
            9: t = 33'sd1335087;
            10: t = 33'sd667544;
            11: t = 33'sd333772;
            12: t = 33'sd166886;
            13: t = 33'sd83443;
            14: t = 33'sd41722;
            15: t = 33'sd20861;
            16: t = 33'sd10430;
            17: t = 33'sd5215;
            18: t = 33'sd2608;
            19: t = 33'sd1304;
            20: t = 33'sd652;
            21: t = 33'sd326;
            22: t = 33'sd163;
            23: t = 33'sd81;
            24: t = 33'sd41;
            25: t = 33'sd20;
            26: t = 33'sd10;
            27: t = 33'sd5;
            28: t = 33'sd3;
            29: t = 33'sd1;
            30: t = 33'sd1;
            default: t = 33'sd0;
        endcase
        return t;
    endfunction

endpackage
`default_nettype wire

// ----- sv/gcdb_sincos.sv -----
// Pipelined rotation-mode CORDIC: sine and cosine of a 32-bit turn, Q30.
// Depends on gcdb_pkg. One register stage per iteration; side data rides along.
`default_nettype none
module gcdb_sincos #(
    parameter int STAGES = 24,
    parameter int SIDE_W = 8
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire logic                       in_valid,
    input  wire logic [31:0]                angle,
    input  wire logic [SIDE_W-1:0]          in_side,
    output logic                            out_valid,
    output gcdb_pkg::q30_t                  sin_q,
    output gcdb_pkg::q30_t                  cos_q,
    output logic [SIDE_W-1:0]               out_side
);
    import gcdb_pkg::*;

    logic [STAGES:0]       v_reg;
    q30_t                  x_reg [STAGES+1];
    q30_t                  y_reg [STAGES+1];
    logic signed [32:0]    z_reg [STAGES+1];
    logic                  n_reg [STAGES+1];
    logic [SIDE_W-1:0]     s_reg [STAGES+1];
    logic signed [32:0]    z0;

    always_comb
    begin
        z0 = $signed({angle[31], angle});
        if (z0 > $signed({1'b0, QUARTER_TURN}))
            z0 = z0 - $signed({1'b0, HALF_TURN});
        else if (z0 < -$signed({1'b0, QUARTER_TURN}))
            z0 = z0 + $signed({1'b0, HALF_TURN});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= CORDIC_K0;
            y_reg[0] <= '0;
            z_reg[0] <= z0;
            n_reg[0] <= (z0 != $signed({angle[31], angle}));
            s_reg[0] <= in_side;
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else if (en)
                v_reg[i+1] <= v_reg[i];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> (i % 32));
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> (i % 32));
                    z_reg[i+1] <= z_reg[i] - atan_turn(i % 32);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> (i % 32));
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> (i % 32));
                    z_reg[i+1] <= z_reg[i] + atan_turn(i % 32);
                end
                n_reg[i+1] <= n_reg[i];
                s_reg[i+1] <= s_reg[i];
            end
        end
    end

    assign out_valid = v_reg[STAGES];
    assign sin_q = n_reg[STAGES] ? -y_reg[STAGES] : y_reg[STAGES];
    assign cos_q = n_reg[STAGES] ? -x_reg[STAGES] : x_reg[STAGES];
    assign out_side = s_reg[STAGES];

endmodule
`default_nettype wire

// ----- sv/gcdb_atan2.sv -----
// Pipelined vectoring-mode CORDIC: atan2(y, x) as a 32-bit turn.
// Depends on gcdb_pkg. One register stage per iteration; side data rides along.
`default_nettype none
module gcdb_atan2 #(
    parameter int STAGES = 24,
    parameter int SIDE_W = 8
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire logic                       in_valid,
    input  gcdb_pkg::q30_t                  y_in,
    input  gcdb_pkg::q30_t                  x_in,
    input  wire logic [SIDE_W-1:0]          in_side,
    output logic                            out_valid,
    output logic [31:0]                     turn,
    output logic [SIDE_W-1:0]               out_side
);
    import gcdb_pkg::*;

    localparam int XW = QW + 2;

    logic [STAGES:0]         v_reg;
    logic signed [XW-1:0]    x_reg [STAGES+1];
    logic signed [XW-1:0]    y_reg [STAGES+1];
    logic signed [32:0]      z_reg [STAGES+1];
    logic                    zero_reg [STAGES+1];
    logic [SIDE_W-1:0]       s_reg [STAGES+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
            s_reg[0] <= in_side;
            if (x_in < 0)
            begin
                x_reg[0] <= -XW'(x_in);
                y_reg[0] <= -XW'(y_in);
                z_reg[0] <= $signed({1'b0, HALF_TURN});
            end
            else
            begin
                x_reg[0] <= XW'(x_in);
                y_reg[0] <= XW'(y_in);
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else if (en)
                v_reg[i+1] <= v_reg[i];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (y_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> (i % 32));
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> (i % 32));
                    z_reg[i+1] <= z_reg[i] + atan_turn(i % 32);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> (i % 32));
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> (i % 32));
                    z_reg[i+1] <= z_reg[i] - atan_turn(i % 32);
                end
                zero_reg[i+1] <= zero_reg[i];
                s_reg[i+1] <= s_reg[i];
            end
        end
    end

    assign out_valid = v_reg[STAGES];
    assign turn = zero_reg[STAGES] ? 32'd0 : z_reg[STAGES][31:0];
    assign out_side = s_reg[STAGES];

endmodule
`default_nettype wire

// ----- sv/gcdb_sqrt.sv -----
// Pipelined integer square root of a 61-bit value, one result bit per stage.
// Depends on gcdb_pkg for q30_t. Side data rides along.
`default_nettype none
module gcdb_sqrt #(
    parameter int SIDE_W = 8
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic                in_valid,
    input  wire logic [60:0]         radicand,
    input  wire logic [SIDE_W-1:0]   in_side,
    output logic                     out_valid,
    output gcdb_pkg::q30_t           root,
    output logic [SIDE_W-1:0]        out_side
);
    import gcdb_pkg::*;

    localparam int N = 31;

    logic [N:0]          v_reg;
    logic [62:0]         rem_reg [N+1];
    logic [30:0]         r_reg [N+1];
    logic [SIDE_W-1:0]   s_reg [N+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= {2'b00, radicand};
            r_reg[0] <= '0;
            s_reg[0] <= in_side;
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        logic [62:0] trial;
        assign trial = ({32'd0, r_reg[i]} << (N - i)) | (63'd1 << (2 * (N - 1 - i)));
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else if (en)
                v_reg[i+1] <= v_reg[i];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_reg[i] >= trial)
                begin
                    rem_reg[i+1] <= rem_reg[i] - trial;
                    r_reg[i+1] <= r_reg[i] | (31'd1 << (N - 1 - i));
                end
                else
                begin
                    rem_reg[i+1] <= rem_reg[i];
                    r_reg[i+1] <= r_reg[i];
                end
                s_reg[i+1] <= s_reg[i];
            end
        end
    end

    assign out_valid = v_reg[N];
    assign root = QW'({1'b0, r_reg[N]});
    assign out_side = s_reg[N];

endmodule
`default_nettype wire

// ----- sv/great_circle_distance_bearing.sv -----
// Great-circle distance (km, rounded up) and initial bearing (deg, north = 360) from a
// configured home position; one remote position per word, one word per cycle sustained.
// The chain runs through the sin/cos CORDIC, two Q30 multiply stages, a square stage, a
// 31-stage square root, the atan2 CORDIC and a scale stage; tready drops only when the
// output register is full and not taken.
// Depends on gcdb_pkg and submodules.
`default_nettype none
module great_circle_distance_bearing #(
    parameter int ANGLE_BITS = 24,
    parameter int CORDIC_STAGES = 24
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // remote_longitude [ANGLE_BITS-1:0], remote_latitude above, zero padded
    input  wire logic [((2*ANGLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // distance_km [14:0], bearing_deg [23:15]
    output logic [23:0]               m_axis_tdata,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [ANGLE_BITS-1:0] cfg_data
);
    import gcdb_pkg::*;

    localparam int SW = 1 + QW;

    logic [ANGLE_BITS-1:0] home_lon_reg, home_lat_reg;
    logic                  home_valid_reg;
    logic                  out_full_reg;
    logic                  en;

    assign cfg_ready = 1'b1;
    assign en = !out_full_reg || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            home_lon_reg <= '0;
            home_lat_reg <= '0;
            home_valid_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_HOME_LON: home_lon_reg <= cfg_data;
                REG_HOME_LAT: home_lat_reg <= cfg_data;
                REG_HOME_VALID: home_valid_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [ANGLE_BITS-1:0] r_lon, r_lat;
    logic [31:0] t_hl, t_l, t_d;
    logic in_fb;
    assign r_lon = s_axis_tdata[ANGLE_BITS-1:0];
    assign r_lat = s_axis_tdata[2*ANGLE_BITS-1:ANGLE_BITS];
    assign t_hl = 32'(home_lat_reg) << (32 - ANGLE_BITS);
    assign t_l = 32'(r_lat) << (32 - ANGLE_BITS);
    assign t_d = (32'(home_lon_reg) << (32 - ANGLE_BITS)) - (32'(r_lon) << (32 - ANGLE_BITS));
    assign in_fb = !home_valid_reg || (r_lon == home_lon_reg && r_lat == home_lat_reg);

    logic v1;
    q30_t s_hl, c_hl, s_l, c_l, s_d, c_d;
    logic fb1, v1b, v1c;
    logic [0:0] sd_b, sd_c;

    gcdb_sincos #(.STAGES(CORDIC_STAGES), .SIDE_W(1)) u_sc_hl (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s_axis_tvalid), .angle(t_hl),
        .in_side(in_fb), .out_valid(v1), .sin_q(s_hl), .cos_q(c_hl), .out_side(fb1));
    gcdb_sincos #(.STAGES(CORDIC_STAGES), .SIDE_W(1)) u_sc_l (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s_axis_tvalid), .angle(t_l),
        .in_side(in_fb), .out_valid(v1b), .sin_q(s_l), .cos_q(c_l), .out_side(sd_b));
    gcdb_sincos #(.STAGES(CORDIC_STAGES), .SIDE_W(1)) u_sc_d (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s_axis_tvalid), .angle(t_d),
        .in_side(in_fb), .out_valid(v1c), .sin_q(s_d), .cos_q(c_d), .out_side(sd_c));

    // multiply stage A: coscos and s_hl*s_l
    logic v2_reg, fb2_reg;
    q30_t cc_reg, shl2_reg, sl2_reg, sd2_reg, cd2_reg;
    logic signed [63:0] ss_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cc_reg <= QW'((64'(c_hl) * 64'(c_l)) >>> 30);
            ss_reg <= 64'(s_hl) * 64'(s_l);
            fb2_reg <= fb1;
            shl2_reg <= s_hl;
            sl2_reg <= s_l;
            sd2_reg <= s_d;
            cd2_reg <= c_d;
        end
    end

    // multiply stage B: central cosine and sine term
    logic v3_reg, fb3_reg;
    q30_t co_reg, si_reg, shl3_reg, sl3_reg;
    logic signed [63:0] co_full;
    assign co_full = (64'(cd2_reg) * 64'(cc_reg) + ss_reg) >>> 30;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (co_full > 64'(Q_ONE))
                co_reg <= Q_ONE;
            else if (co_full < -64'(Q_ONE))
                co_reg <= -Q_ONE;
            else
                co_reg <= QW'(co_full);
            si_reg <= QW'(-((64'(sd2_reg) * 64'(cc_reg)) >>> 30));
            fb3_reg <= fb2_reg;
            shl3_reg <= shl2_reg;
            sl3_reg <= sl2_reg;
        end
    end

    // square stage: radicand, second bearing term
    logic v4_reg, fb4_reg;
    logic [60:0] rad_reg;
    q30_t co4_reg, si4_reg, co2_reg;
    logic signed [67:0] sq;
    assign sq = 68'sd1 <<< 60;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (en)
            v4_reg <= v3_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg <= 61'(sq - 68'(64'(co_reg) * 64'(co_reg)));
            co2_reg <= QW'(64'(sl3_reg) - ((64'(shl3_reg) * 64'(co_reg)) >>> 30));
            co4_reg <= co_reg;
            si4_reg <= si_reg;
            fb4_reg <= fb3_reg;
        end
    end

    logic v5;
    q30_t s_root;
    logic [SW-1:0] side5;
    gcdb_sqrt #(.SIDE_W(SW)) u_sqrt (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v4_reg), .radicand(rad_reg),
        .in_side({fb4_reg, co4_reg}), .out_valid(v5), .root(s_root),
        .out_side(side5));

    // bearing atan2 is delayed to run alongside the central angle
    logic v6, v6b;
    logic [31:0] ca_turn, az_turn;
    logic [0:0] fb6, fb6b;
    q30_t si_d, co2_d;
    logic [2*QW-1:0] bear_dly_reg [32];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bear_dly_reg[0] <= {si4_reg, co2_reg};
            for (int k = 1; k < 32; k++)
                bear_dly_reg[k] <= bear_dly_reg[k-1];
        end
    end
    assign si_d = bear_dly_reg[31][2*QW-1:QW];
    assign co2_d = bear_dly_reg[31][QW-1:0];

    gcdb_atan2 #(.STAGES(CORDIC_STAGES), .SIDE_W(1)) u_at_ca (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v5), .y_in(s_root),
        .x_in(side5[QW-1:0]), .in_side(side5[SW-1]), .out_valid(v6),
        .turn(ca_turn), .out_side(fb6));
    gcdb_atan2 #(.STAGES(CORDIC_STAGES), .SIDE_W(1)) u_at_az (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v5), .y_in(si_d),
        .x_in(co2_d), .in_side(side5[SW-1]), .out_valid(v6b), .turn(az_turn),
        .out_side(fb6b));

    // scale stage
    logic v7_reg, fb7_reg;
    logic [63:0] dprod_reg, bprod_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v7_reg <= 1'b0;
        else if (en)
            v7_reg <= v6;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dprod_reg <= 64'(ca_turn) * 64'(DIST_SCALE);
            bprod_reg <= 64'(az_turn) * 64'd360;
            fb7_reg <= fb6[0];
        end
    end

    logic [63:0] dist_sum, bear_sum;
    logic [DIST_W-1:0] dist_v;
    logic [BEAR_W-1:0] bear_v;
    assign dist_sum = dprod_reg + ((64'd1 << 47) - 64'd1);
    assign bear_sum = bprod_reg + (64'd1 << 31);
    always_comb
    begin
        dist_v = dist_sum[47+DIST_W-1:47];
        bear_v = bear_sum[32+BEAR_W-1:32];
        if (bear_v == '0)
            bear_v = BEAR_W'(360);
        if (fb7_reg)
        begin
            dist_v = DIST_W'(1);
            bear_v = '0;
        end
    end

    logic [23:0] out_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_full_reg <= 1'b0;
        else if (en)
            out_full_reg <= v7_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= {bear_v, dist_v};
    end

    assign m_axis_tvalid = out_full_reg;
    assign m_axis_tdata = out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("output word changed under stall");
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready not tied to output space");
    assert property (@(posedge clk) disable iff (!rst_n)
        (v1b == v1) && (v1c == v1) && (!v1 || (sd_b[0] == fb1 && sd_c[0] == fb1)))
        else $error("sin/cos lanes out of step");
    assert property (@(posedge clk) disable iff (!rst_n)
        (v6b == v6) && (!v6 || fb6b[0] == fb6[0]))
        else $error("atan2 lanes out of step");
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[23:15] <= 9'd360)
        else $error("bearing out of range");

endmodule
`default_nettype wire
